[rtl/recursive_least_squares_line_fit_assert.svh]
// Assertion macros for the line-fit block.
// Used by the RTL files that carry concurrent checks; depends on nothing.
`ifndef RECURSIVE_LEAST_SQUARES_LINE_FIT_ASSERT_SVH
`define RECURSIVE_LEAST_SQUARES_LINE_FIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define RLSF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line fit check failed");

// Antecedent implies consequent in the next cycle.
`define RLSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line fit check failed");

`endif

[rtl/rlsf_pkg.sv]
// Shared types, constants and the saturation function of the line-fit block.
// No dependencies.
`default_nettype none

package rlsf_pkg;

    localparam int X_WIDTH   = 32;
    localparam int P_WIDTH   = 48;
    localparam int OUT_WIDTH = 48;
    localparam int WIDE      = 128;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_E_DET,
        ST_E_A,
        ST_E_B,
        ST_E_X0,
        ST_E_X1,
        ST_E_OFF,
        ST_E_P00,
        ST_E_P11,
        ST_R_M01,
        ST_R_M10,
        ST_R_M11,
        ST_R_S,
        ST_R_N00M,
        ST_R_N00D,
        ST_R_N01M,
        ST_R_N01D,
        ST_R_N10M,
        ST_R_N10D,
        ST_R_N11M,
        ST_R_N11D,
        ST_R_E,
        ST_R_K0,
        ST_R_K1,
        ST_R_B,
        ST_R_A,
        ST_FIN
    } rlsf_state_t;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_sts_t;

    // Clamp a wide signed value to a signed field of the given width (1..64).
    function automatic logic signed [63:0] sat(input logic signed [WIDE-1:0] a,
                                               input int bits);
        logic signed [WIDE-1:0] mx;
        logic signed [WIDE-1:0] mn;
        mx = (128'sd1 <<< (bits - 1)) - 128'sd1;
        mn = -mx - 128'sd1;
        if (a > mx)
            return mx[63:0];
        else if (a < mn)
            return mn[63:0];
        else
            return a[63:0];
    endfunction

endpackage

`default_nettype wire

[rtl/rlsf_in_if.sv]
// Sample channel of the line-fit block: valid, ready and one (x, y) request.
// No dependencies.
`default_nettype none

interface rlsf_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;

    modport source (output valid, output action, output x_value, output y_value,
                    input ready);
    modport sink   (input valid, input action, input x_value, input y_value,
                    output ready);
endinterface

`default_nettype wire

[rtl/rlsf_out_if.sv]
// Result channel of the line-fit block: valid, ready and one fitted request.
// No dependencies.
`default_nettype none

interface rlsf_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] slope;
    logic signed [47:0] intercept;
    logic               ready_res;
    logic               degenerate;

    modport source (output valid, output slope, output intercept,
                    output ready_res, output degenerate, input ready);
    modport sink   (input valid, input slope, input intercept,
                    input ready_res, input degenerate, output ready);
endinterface

`default_nettype wire

[rtl/rlsf_alu.sv]
// Shared iterative unit: 64x64 signed shift-add multiply, 128/128 signed divide.
// Depends on rlsf_pkg.
`default_nettype none

module rlsf_alu
    import rlsf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire alu_ctl_t               ctl,
    input  wire logic signed [WIDE-1:0] opa,
    input  wire logic signed [WIDE-1:0] opb,
    output alu_sts_t                    sts,
    output logic signed [WIDE-1:0]      result
);

    localparam int MUL_STEPS = 64;
    localparam int DIV_STEPS = 128;

    logic            busy_reg;
    logic            done_reg;
    logic [6:0]      cnt_reg;
    alu_op_t         op_reg;
    logic            neg_reg;
    logic [WIDE:0]   acc_reg;
    logic [WIDE-1:0] q_reg;
    logic [WIDE-1:0] m_reg;

    logic [63:0]     mag_a64;
    logic [63:0]     mag_b64;
    logic [WIDE-1:0] mag_a;
    logic [WIDE-1:0] mag_b;
    logic [WIDE:0]   trial;
    logic            fits;
    logic            last;
    logic [WIDE-1:0] raw;

    assign mag_a64 = opa[63]     ? 64'd0 - opa[63:0] : opa[63:0];
    assign mag_b64 = opb[63]     ? 64'd0 - opb[63:0] : opb[63:0];
    assign mag_a   = opa[WIDE-1] ? '0 - opa          : opa;
    assign mag_b   = opb[WIDE-1] ? '0 - opb          : opb;

    assign trial = {acc_reg[WIDE-1:0], q_reg[WIDE-1]};
    assign fits  = trial >= {1'b0, m_reg};
    assign last  = (op_reg == ALU_MUL) ? (cnt_reg == 7'(MUL_STEPS - 1))
                                       : (cnt_reg == 7'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !ctl.start && last;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            op_reg  <= ctl.op;
            acc_reg <= '0;
            if (ctl.op == ALU_MUL)
            begin
                q_reg   <= {64'd0, mag_a64};
                m_reg   <= {64'd0, mag_b64};
                neg_reg <= opa[63] ^ opb[63];
            end
            else
            begin
                q_reg   <= mag_a;
                m_reg   <= mag_b;
                neg_reg <= opa[WIDE-1] ^ opb[WIDE-1];
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == ALU_MUL)
            begin
                if (q_reg[0])
                    acc_reg <= acc_reg + {1'b0, m_reg};
                m_reg <= m_reg << 1;
                q_reg <= q_reg >> 1;
            end
            else
            begin
                // restoring step: one quotient bit per cycle
                acc_reg <= fits ? trial - {1'b0, m_reg} : trial;
                q_reg   <= {q_reg[WIDE-2:0], fits};
            end
        end
    end

    assign raw    = (op_reg == ALU_MUL) ? acc_reg[WIDE-1:0] : q_reg;
    assign result = neg_reg ? $signed('0 - raw) : $signed(raw);

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

`default_nettype wire

[rtl/recursive_least_squares_line_fit.sv]
// Top level of the recursive least-squares straight-line fit.
// Depends on rlsf_pkg, rlsf_in_if, rlsf_out_if, rlsf_alu and the assert header.
//
//  channel   dir  handshake        payload
//  sample    in   valid / ready    action, x_value, y_value
//  result    out  valid / ready    slope, intercept, ready_res, degenerate
//
// One request at a time. Every multiply and every divide runs in the single shared
// unit; the two-point solve uses four multiplies and four divides and an RLS update
// thirteen multiplies and four divides, while an initialize request uses none; a
// degenerate request stops early.
// Reset clears the sequencer and the fit state at once (no clearing pass).
// A finished result waits in the output register; the next request is taken
// while it waits, and only the write of the following result stalls on it.
`default_nettype none

module recursive_least_squares_line_fit
    import rlsf_pkg::*;
#(
    parameter int COEF_WIDTH = 48
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    rlsf_in_if.sink   sample,
    rlsf_out_if.source result
);

    `include "recursive_least_squares_line_fit_assert.svh"

    localparam logic signed [63:0] SLOPE_RST = sat(128'sd1 <<< 32, COEF_WIDTH);

    rlsf_state_t state_reg, state_next;

    // fit state
    logic signed [COEF_WIDTH-1:0] slope_reg;
    logic signed [COEF_WIDTH-1:0] intercept_reg;
    logic signed [P_WIDTH-1:0]    p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [X_WIDTH-1:0]    fx_reg, fy_reg;
    logic                         pending_reg;
    logic                         init_reg;

    // request and scratch
    logic                         act_reg;
    logic signed [X_WIDTH-1:0]    x_reg, y_reg;
    logic                         degen_reg;
    logic                         wait_reg;
    logic signed [WIDE-1:0]       det_reg, acc_reg, s_reg;
    logic signed [63:0]           u0_reg, u1_reg, w0_reg, w1_reg, e_reg, k0_reg, k1_reg;
    logic signed [P_WIDTH-1:0]    n00_reg, n01_reg, n10_reg, n11_reg;

    // output register
    logic                         res_valid_reg;
    logic signed [OUT_WIDTH-1:0]  res_slope_reg, res_icpt_reg;
    logic                         res_rdy_reg, res_degen_reg;

    alu_ctl_t               alu_ctl;
    alu_sts_t               alu_sts;
    logic signed [WIDE-1:0] opa, opb, prod;
    logic                   op_state;
    logic signed [X_WIDTH:0] dx, dy;
    logic signed [WIDE-1:0] s_calc;
    logic                   take;
    logic                   out_free;

    assign take     = sample.valid && sample.ready;
    assign out_free = !res_valid_reg || result.ready;
    assign dx       = (X_WIDTH + 1)'(x_reg) - (X_WIDTH + 1)'(fx_reg);
    assign dy       = (X_WIDTH + 1)'(y_reg) - (X_WIDTH + 1)'(fy_reg);
    assign s_calc   = (128'sd1 <<< 40) + WIDE'(w0_reg) + (prod >>> 16);
    assign op_state = (state_reg != ST_IDLE) && (state_reg != ST_DISPATCH)
                   && (state_reg != ST_FIN);

    rlsf_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .opa    (opa),
        .opb    (opb),
        .sts    (alu_sts),
        .result (prod)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (take) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                if (!act_reg)
                    state_next = ST_FIN;
                else if (pending_reg)
                    state_next = (dx == '0) ? ST_FIN : ST_E_DET;
                else
                    state_next = ST_R_M01;
            end
            ST_FIN:      if (out_free) state_next = ST_IDLE;
            default:
            begin
                if (alu_sts.done)
                begin
                    unique case (state_reg)
                        ST_E_DET:  state_next = ST_E_A;
                        ST_E_A:    state_next = ST_E_B;
                        ST_E_B:    state_next = ST_E_X0;
                        ST_E_X0:   state_next = ST_E_X1;
                        ST_E_X1:   state_next = ST_E_OFF;
                        ST_E_OFF:  state_next = ST_E_P00;
                        ST_E_P00:  state_next = ST_E_P11;
                        ST_E_P11:  state_next = ST_FIN;
                        ST_R_M01:  state_next = ST_R_M10;
                        ST_R_M10:  state_next = ST_R_M11;
                        ST_R_M11:  state_next = ST_R_S;
                        ST_R_S:    state_next = (s_calc == '0) ? ST_FIN : ST_R_N00M;
                        ST_R_N00M: state_next = ST_R_N00D;
                        ST_R_N00D: state_next = ST_R_N01M;
                        ST_R_N01M: state_next = ST_R_N01D;
                        ST_R_N01D: state_next = ST_R_N10M;
                        ST_R_N10M: state_next = ST_R_N10D;
                        ST_R_N10D: state_next = ST_R_N11M;
                        ST_R_N11M: state_next = ST_R_N11D;
                        ST_R_N11D: state_next = ST_R_E;
                        ST_R_E:    state_next = ST_R_K0;
                        ST_R_K0:   state_next = ST_R_K1;
                        ST_R_K1:   state_next = ST_R_B;
                        ST_R_B:    state_next = ST_R_A;
                        ST_R_A:    state_next = ST_FIN;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    // operand selection for the shared unit
    always_comb
    begin
        alu_ctl.start = op_state && !wait_reg;
        alu_ctl.op    = ALU_MUL;
        opa           = '0;
        opb           = '0;
        unique case (state_reg)
            ST_E_DET:  begin opa = WIDE'(dx);        opb = WIDE'(dx);        end
            ST_E_A:
            begin
                alu_ctl.op = ALU_DIV;
                opa        = WIDE'(dy) <<< 32;
                opb        = WIDE'(dx);
            end
            ST_E_B:    begin opa = WIDE'(fx_reg);    opb = WIDE'(slope_reg); end
            ST_E_X0:   begin opa = WIDE'(fx_reg);    opb = WIDE'(fx_reg);    end
            ST_E_X1:   begin opa = WIDE'(x_reg);     opb = WIDE'(x_reg);     end
            ST_E_OFF:
            begin
                alu_ctl.op = ALU_DIV;
                opa        = WIDE'((X_WIDTH + 1)'(fx_reg) + (X_WIDTH + 1)'(x_reg)) <<< 56;
                opb        = det_reg;
            end
            ST_E_P00:  begin alu_ctl.op = ALU_DIV; opa = acc_reg <<< 40;   opb = det_reg; end
            ST_E_P11:  begin alu_ctl.op = ALU_DIV; opa = 128'sd2 <<< 72;  opb = det_reg; end
            ST_R_M01:  begin opa = WIDE'(p01_reg);   opb = WIDE'(x_reg);     end
            ST_R_M10:  begin opa = WIDE'(p10_reg);   opb = WIDE'(x_reg);     end
            ST_R_M11:  begin opa = WIDE'(p11_reg);   opb = WIDE'(x_reg);     end
            ST_R_S:    begin opa = WIDE'(x_reg);     opb = WIDE'(w1_reg);    end
            ST_R_N00M: begin opa = WIDE'(u0_reg);    opb = WIDE'(w0_reg);    end
            ST_R_N01M: begin opa = WIDE'(u0_reg);    opb = WIDE'(w1_reg);    end
            ST_R_N10M: begin opa = WIDE'(u1_reg);    opb = WIDE'(w0_reg);    end
            ST_R_N11M: begin opa = WIDE'(u1_reg);    opb = WIDE'(w1_reg);    end
            ST_R_N00D, ST_R_N01D, ST_R_N10D, ST_R_N11D:
            begin
                alu_ctl.op = ALU_DIV;
                opa        = acc_reg;
                opb        = s_reg;
            end
            ST_R_E:    begin opa = WIDE'(slope_reg); opb = WIDE'(x_reg);     end
            ST_R_K0:   begin opa = WIDE'(n01_reg);   opb = WIDE'(x_reg);     end
            ST_R_K1:   begin opa = WIDE'(n11_reg);   opb = WIDE'(x_reg);     end
            ST_R_B:    begin opa = WIDE'(e_reg);     opb = WIDE'(k0_reg);    end
            ST_R_A:    begin opa = WIDE'(e_reg);     opb = WIDE'(k1_reg);    end
            default:   begin opa = '0;               opb = '0;               end
        endcase
    end

    // sequencer and fit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            slope_reg     <= COEF_WIDTH'(SLOPE_RST);
            intercept_reg <= '0;
            p00_reg       <= '0;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= '0;
            fx_reg        <= '0;
            fy_reg        <= '0;
            pending_reg   <= 1'b0;
            init_reg      <= 1'b0;
            degen_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // block a new start request until the unit reports back
            if (alu_ctl.start)
                wait_reg <= 1'b1;
            else if (alu_sts.done)
                wait_reg <= 1'b0;

            if (state_reg == ST_FIN && out_free)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;

            if (state_reg == ST_DISPATCH)
            begin
                // equal x on the exact solve keeps the state and flags it
                degen_reg <= act_reg && pending_reg && (dx == '0);
                if (!act_reg)
                begin
                    fx_reg      <= x_reg;
                    fy_reg      <= y_reg;
                    pending_reg <= 1'b1;
                    init_reg    <= 1'b1;
                end
            end

            if (alu_sts.done)
            begin
                case (state_reg)
                    ST_E_A:
                        slope_reg <= COEF_WIDTH'(sat(prod, COEF_WIDTH));
                    ST_E_B:
                        intercept_reg <= COEF_WIDTH'(sat((WIDE'(fy_reg) <<< 16)
                                         - (prod >>> 16), COEF_WIDTH));
                    ST_E_OFF:
                    begin
                        p01_reg <= P_WIDTH'(sat(-prod, P_WIDTH));
                        p10_reg <= P_WIDTH'(sat(-prod, P_WIDTH));
                    end
                    ST_E_P00:
                        p00_reg <= P_WIDTH'(sat(prod, P_WIDTH));
                    ST_E_P11:
                    begin
                        p11_reg     <= P_WIDTH'(sat(prod, P_WIDTH));
                        pending_reg <= 1'b0;
                    end
                    ST_R_S:
                        if (s_calc == '0)
                            degen_reg <= 1'b1;
                    ST_R_B:
                        intercept_reg <= COEF_WIDTH'(sat(WIDE'(intercept_reg)
                                         + (prod >>> 40), COEF_WIDTH));
                    ST_R_A:
                    begin
                        slope_reg <= COEF_WIDTH'(sat(WIDE'(slope_reg)
                                     + (prod >>> 40), COEF_WIDTH));
                        // commit the new covariance
                        p00_reg   <= n00_reg;
                        p01_reg   <= n01_reg;
                        p10_reg   <= n10_reg;
                        p11_reg   <= n11_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // request capture, scratch and output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            act_reg <= sample.action;
            x_reg   <= sample.x_value;
            y_reg   <= sample.y_value;
        end

        if (alu_sts.done)
        begin
            case (state_reg)
                ST_E_DET:  det_reg <= prod;
                ST_E_X0:   acc_reg <= prod;
                ST_E_X1:   acc_reg <= acc_reg + prod;
                ST_R_M01:  u0_reg  <= sat(WIDE'(p00_reg) + (prod >>> 16), 64);
                ST_R_M10:  w0_reg  <= sat(WIDE'(p00_reg) + (prod >>> 16), 64);
                ST_R_M11:
                begin
                    u1_reg <= sat(WIDE'(p10_reg) + (prod >>> 16), 64);
                    w1_reg <= sat(WIDE'(p01_reg) + (prod >>> 16), 64);
                end
                ST_R_S:    s_reg   <= s_calc;
                ST_R_N00M, ST_R_N01M, ST_R_N10M, ST_R_N11M:
                    acc_reg <= prod;
                ST_R_N00D: n00_reg <= P_WIDTH'(sat(WIDE'(p00_reg) - prod, P_WIDTH));
                ST_R_N01D: n01_reg <= P_WIDTH'(sat(WIDE'(p01_reg) - prod, P_WIDTH));
                ST_R_N10D: n10_reg <= P_WIDTH'(sat(WIDE'(p10_reg) - prod, P_WIDTH));
                ST_R_N11D: n11_reg <= P_WIDTH'(sat(WIDE'(p11_reg) - prod, P_WIDTH));
                ST_R_E:
                    e_reg <= sat((WIDE'(y_reg) <<< 16) - WIDE'(intercept_reg)
                                 - (prod >>> 16), 64);
                ST_R_K0:   k0_reg  <= sat(WIDE'(n00_reg) + (prod >>> 16), 64);
                ST_R_K1:   k1_reg  <= sat(WIDE'(n10_reg) + (prod >>> 16), 64);
                default:
                begin
                end
            endcase
        end

        if (state_reg == ST_FIN && out_free)
        begin
            res_slope_reg <= OUT_WIDTH'(64'(slope_reg));
            res_icpt_reg  <= OUT_WIDTH'(64'(intercept_reg));
            res_rdy_reg   <= init_reg;
            res_degen_reg <= degen_reg;
        end
    end

    assign sample.ready      = (state_reg == ST_IDLE);
    assign result.valid      = res_valid_reg;
    assign result.slope      = res_slope_reg;
    assign result.intercept  = res_icpt_reg;
    assign result.ready_res  = res_rdy_reg;
    assign result.degenerate = res_degen_reg;

    // an accepted request is always dispatched next
    `RLSF_ASSERT_NEXT(a_take_dispatch, clk, rst_n, take, state_reg == ST_DISPATCH)
    // the sequencer never starts the unit while it is still working
    `RLSF_ASSERT_SAME(a_start_idle_alu, clk, rst_n, alu_ctl.start, !alu_sts.busy)
    // the unit reports back only to a sequencer that waits for it
    `RLSF_ASSERT_SAME(a_done_waited, clk, rst_n, alu_sts.done, wait_reg && op_state)

endmodule

`default_nettype wire
